>>> design/kmc_pkg.sv
// kmc_pkg: shared constants, base decode and control structs for the k-mer counter
// no dependencies; imported by every module of the block

package kmc_pkg;

	// parameter defaults
	localparam int K_DEF          = 4;
	localparam int COUNT_BITS_DEF = 32;

	// fixed field widths
	localparam int LEN_W       = 3;
	localparam int CHAR_W      = 8;
	localparam int QIDX_W      = 8;
	localparam int COUNT_OUT_W = 32;

	localparam logic [LEN_W-1:0] KMER_LENGTH_RESET = 3'd4;

	// action codes
	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// ascii base characters
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC = 8'h43;
	localparam logic [CHAR_W-1:0] CH_UG = 8'h47;
	localparam logic [CHAR_W-1:0] CH_UT = 8'h54;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC = 8'h63;
	localparam logic [CHAR_W-1:0] CH_LG = 8'h67;
	localparam logic [CHAR_W-1:0] CH_LT = 8'h74;

	// 2-bit base codes
	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_t;

	// request handed from the window tracker to the count table
	typedef struct packed {
		logic              incr;
		logic              query;
		logic [QIDX_W-1:0] echo;
	} req_ctl_t;

	// query result leaving the count table
	typedef struct packed {
		logic                   valid;
		logic [COUNT_OUT_W-1:0] count;
		logic [QIDX_W-1:0]      echo;
	} res_t;

	function automatic base_t base_decode(input logic [CHAR_W-1:0] ch);
		base_t b;
		b.ok   = 1'b1;
		b.code = CODE_A;
		case (ch) inside
			CH_UA, CH_LA: b.code = CODE_A;
			CH_UC, CH_LC: b.code = CODE_C;
			CH_UG, CH_LG: b.code = CODE_G;
			CH_UT, CH_LT: b.code = CODE_T;
			default:      b.ok   = 1'b0;
		endcase
		return b;
	endfunction

endpackage

>>> design/kmc_ifs.sv
// kmc_ifs: valid/ready channel interfaces for input items, results and config writes
// depends on kmc_pkg for field widths

interface kmc_item_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [kmc_pkg::CHAR_W-1:0]   base_char;
	logic                         read_start;
	logic [kmc_pkg::QIDX_W-1:0]   kmer_index;

	modport source (output valid, action, base_char, read_start, kmer_index, input ready);
	modport sink   (input valid, action, base_char, read_start, kmer_index, output ready);
endinterface

interface kmc_result_if;
	logic                             valid;
	logic                             ready;
	logic [kmc_pkg::COUNT_OUT_W-1:0]  count_value;
	logic [kmc_pkg::QIDX_W-1:0]       echoed_index;

	modport source (output valid, count_value, echoed_index, input ready);
	modport sink   (input valid, count_value, echoed_index, output ready);
endinterface

interface kmc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [kmc_pkg::LEN_W-1:0]   kmer_length;

	modport source (output valid, kmer_length, input ready);
	modport sink   (input valid, kmer_length, output ready);
endinterface

>>> design/kmer_histogram_counter_unit.sv
// kmer_histogram_counter_unit: top level of the 2-bit dna k-mer histogram
// depends on kmc_pkg, kmc_ifs, kmc_window and kmc_table
//
//  channel  dir  beat carries                                   notes
//  item     in   action, base_char, read_start, kmer_index      push base or query count
//  result   out  count_value, echoed_index                      one beat per query
//  cfg      in   kmer_length                                    always ready, write when idle
//
// one item per cycle when no clearing pass runs and no query result is stalled; a query result
// reaches the port through the memory read register, then the output register; a push gives no result
// the table read-modify-write is the rate setter: read at accept, write in the cycle after,
// with forwarding when the next beat hits the same entry
// after reset a clearing pass zeroes all 4**K entries of the count memory, item.ready low meanwhile
// a query only stalls the input when the output register is full and not taken

module kmer_histogram_counter_unit #(
	parameter int K          = kmc_pkg::K_DEF,
	parameter int COUNT_BITS = kmc_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	kmc_item_if.sink       item,
	kmc_result_if.source   result,
	kmc_cfg_if.sink        cfg
);
	import kmc_pkg::*;

	localparam int IDX_W = 2 * K;

	logic [LEN_W-1:0]       kmer_length_q;
	logic                   out_valid_q;
	logic [COUNT_OUT_W-1:0] count_q;
	logic [QIDX_W-1:0]      echo_q;

	logic             accept;
	logic             push_accept;
	logic             query_accept;
	logic             req_valid;
	logic             res_take;
	logic             clr_busy;
	logic             s1_stall;
	req_ctl_t         req_ctl;
	logic [IDX_W-1:0] req_idx;
	res_t             res;

	// config register; the user must write it only while idle, the block does not enforce this
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KMER_LENGTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			kmer_length_q <= cfg.kmer_length;
		end
	end

	// a query parked in stage 1 waits for room in the output register
	assign res_take     = res.valid && (!out_valid_q || result.ready);
	assign s1_stall     = res.valid && !res_take;
	assign item.ready   = !clr_busy && !s1_stall;
	assign accept       = item.valid && item.ready;
	assign push_accept  = accept && (item.action == ACT_PUSH);
	assign query_accept = accept && (item.action == ACT_QUERY);
	assign req_valid    = accept && (req_ctl.incr || req_ctl.query);

	kmc_window #(
		.K (K)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_accept  (push_accept),
		.query_accept (query_accept),
		.kmer_length  (kmer_length_q),
		.action       (item.action),
		.base_char    (item.base_char),
		.read_start   (item.read_start),
		.kmer_index   (item.kmer_index),
		.req_ctl      (req_ctl),
		.req_idx      (req_idx)
	);

	kmc_table #(
		.K          (K),
		.COUNT_BITS (COUNT_BITS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ctl   (req_ctl),
		.req_idx   (req_idx),
		.res_take  (res_take),
		.clr_busy  (clr_busy),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			count_q <= res.count;
			echo_q  <= res.echo;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.count_value  = count_q;
	assign result.echoed_index = echo_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && out_valid_q && !result.ready) |-> !item.ready)
		else $error("input taken while a query result is stuck in stage 1");

endmodule

>>> design/kmc_window.sv
// kmc_window: base decode, k-mer window and fill tracking, query index masking
// depends on kmc_pkg

module kmc_window #(
	parameter int K = kmc_pkg::K_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_accept,
	input  logic                        query_accept,
	input  logic [kmc_pkg::LEN_W-1:0]   kmer_length,
	input  logic                        action,
	input  logic [kmc_pkg::CHAR_W-1:0]  base_char,
	input  logic                        read_start,
	input  logic [kmc_pkg::QIDX_W-1:0]  kmer_index,
	output kmc_pkg::req_ctl_t           req_ctl,
	output logic [2*K-1:0]              req_idx
);
	import kmc_pkg::*;

	localparam int IDX_W  = 2 * K;
	localparam int HELD_W = $clog2(K + 1);

	logic [IDX_W-1:0]  window_q;
	logic [HELD_W-1:0] held_q;

	logic [HELD_W-1:0] len_eff;
	logic [IDX_W-1:0]  len_mask;
	logic [QIDX_W-1:0] q_mask;
	logic [QIDX_W-1:0] q_echo;
	logic [IDX_W-1:0]  q_idx;
	logic [HELD_W-1:0] held_lim;
	logic [HELD_W-1:0] held_c;
	logic [HELD_W-1:0] held_d;
	logic [IDX_W-1:0]  window_d;
	logic              hit;
	base_t             base;

	// zero acts as one, anything above K acts as K
	always_comb begin
		if (kmer_length == '0) begin
			len_eff = HELD_W'(1);
		end else if (int'(kmer_length) > K) begin
			len_eff = HELD_W'(K);
		end else begin
			len_eff = HELD_W'(kmer_length);
		end
	end

	always_comb begin
		for (int i = 0; i < IDX_W; i++) begin
			len_mask[i] = (i >> 1) < int'(len_eff);
		end
		for (int i = 0; i < QIDX_W; i++) begin
			q_mask[i] = (i < IDX_W) && ((i >> 1) < int'(len_eff));
		end
		q_echo = kmer_index & q_mask;
		for (int i = 0; i < IDX_W; i++) begin
			q_idx[i] = (i < QIDX_W) ? q_echo[i % QIDX_W] : 1'b0;
		end
	end

	// bases held never exceed the length in use, on a push or a query
	assign held_lim = (held_q > len_eff) ? len_eff : held_q;

	always_comb begin
		base     = base_decode(base_char);
		held_c   = held_lim;
		window_d = window_q;
		if (read_start) begin
			held_c   = '0;
			window_d = '0;
		end
		held_d = held_c;
		hit    = 1'b0;
		if (!base.ok) begin
			// bad character restarts the window
			held_d   = '0;
			window_d = '0;
		end else begin
			window_d = (window_d << 2) | IDX_W'(base.code);
			if (held_c < len_eff) begin
				held_d = held_c + HELD_W'(1);
			end
			hit = (held_d == len_eff);
		end
	end

	always_comb begin
		req_ctl.query = (action == ACT_QUERY);
		req_ctl.incr  = (action == ACT_PUSH) && hit;
		req_ctl.echo  = q_echo;
		req_idx       = req_ctl.query ? q_idx : (window_d & len_mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			held_q   <= '0;
		end else if (push_accept) begin
			window_q <= window_d;
			held_q   <= held_d;
		end else if (query_accept) begin
			held_q   <= held_lim;
		end
	end

	a_bad_char_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(push_accept && !base.ok) |=> (held_q == '0 && window_q == '0))
		else $error("invalid base did not empty the window");

endmodule

>>> design/kmc_table.sv
// kmc_table: count memory with reset clearing pass, read-modify-write stage and forwarding
// depends on kmc_pkg

module kmc_table #(
	parameter int K          = kmc_pkg::K_DEF,
	parameter int COUNT_BITS = kmc_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  kmc_pkg::req_ctl_t  req_ctl,
	input  logic [2*K-1:0]     req_idx,
	input  logic               res_take,
	output logic               clr_busy,
	output kmc_pkg::res_t      res
);
	import kmc_pkg::*;

	localparam int IDX_W = 2 * K;
	localparam int DEPTH = 1 << IDX_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] mem [DEPTH];

	logic                  clr_busy_q;
	logic [IDX_W-1:0]      clr_addr_q;
	logic                  incr_s1;
	logic                  query_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [QIDX_W-1:0]     echo_s1;
	logic                  fwd_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;
	logic [COUNT_BITS-1:0] rd_q;

	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] cnt_next;
	logic                  we;
	logic [IDX_W-1:0]      wa;
	logic [COUNT_BITS-1:0] wd;

	// a write at the same edge as the read is not seen by the memory
	assign cur      = fwd_s1 ? fwd_data_s1 : rd_q;
	assign cnt_next = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);

	assign we = clr_busy_q || incr_s1;
	assign wa = clr_busy_q ? clr_addr_q : idx_s1;
	assign wd = clr_busy_q ? '0 : cnt_next;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req_valid) begin
			rd_q <= mem[req_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_s1  <= 1'b0;
			query_s1 <= 1'b0;
		end else if (req_valid) begin
			incr_s1  <= req_ctl.incr;
			query_s1 <= req_ctl.query;
		end else begin
			incr_s1 <= 1'b0;
			if (res_take) begin
				query_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			idx_s1      <= req_idx;
			echo_s1     <= req_ctl.echo;
			fwd_s1      <= incr_s1 && (idx_s1 == req_idx);
			fwd_data_s1 <= cnt_next;
		end
	end

	assign clr_busy  = clr_busy_q;
	assign res.valid = query_s1;
	assign res.count = COUNT_OUT_W'(cur);
	assign res.echo  = echo_s1;

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> !clr_busy_q)
		else $error("table request during clearing pass");

	a_fwd_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && incr_s1 && idx_s1 == req_idx) |=> fwd_s1)
		else $error("missed forwarding of a back-to-back increment");

endmodule

>>> tb/kmer_histogram_counter_unit_tb.sv
// kmer_histogram_counter_unit_tb: self-checking bench for the 2-bit dna k-mer histogram unit
// drives base and query beats with random gaps and checks every count against its own predictor
// depends on kmc_pkg, kmc_ifs and kmer_histogram_counter_unit

module kmer_histogram_counter_unit_tb;
	import kmc_pkg::*;

	localparam int K_USED        = K_DEF;
	localparam int SLOTS         = 1 << (2 * K_USED);
	// longest quiet stretch: reset plus the clearing pass, a few settle waits, long rx stalls
	localparam int STALL_LIMIT   = 3000;
	// a push can still be in its read-modify-write when the last count beat leaves
	localparam int SETTLE_CYCLES = 8;
	// random beats per length setting, seven settings in all
	localparam int SEGMENT_ITEMS = 286;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] count;
		logic [QIDX_W-1:0]      index;
	} count_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	kmc_item_if   item_bus();
	kmc_result_if result_bus();
	kmc_cfg_if    cfg_bus();

	kmer_histogram_counter_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// predictor copy of the block state
	logic [LEN_W-1:0]       kmer_len_q;
	logic [2*K_USED-1:0]    window_q;
	int                     bases_seen;
	logic [COUNT_OUT_W-1:0] hist_counts [SLOTS];

	// counts still owed by the block, oldest first
	count_beat_t pending_counts [$];

	int mismatches  = 0;
	int quiet_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// clock, period 2
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// register values 0 and above K are folded into range
	function automatic int active_length();
		if (kmer_len_q == '0)
			return 1;
		if (int'(kmer_len_q) > K_USED)
			return K_USED;
		return int'(kmer_len_q);
	endfunction

	function automatic logic [QIDX_W-1:0] len_mask(input int n);
		return QIDX_W'((1 << (2 * n)) - 1);
	endfunction

	// ascii to 2-bit code, returns 0 for anything that is not acgt in either case
	function automatic logic decode_char(input logic [CHAR_W-1:0] ch, output logic [1:0] code);
		code = CODE_A;
		case (ch)
			CH_UA, CH_LA: code = CODE_A;
			CH_UC, CH_LC: code = CODE_C;
			CH_UG, CH_LG: code = CODE_G;
			CH_UT, CH_LT: code = CODE_T;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// apply one accepted beat to the predictor, queue a count for a query
	task automatic tally_beat(input logic act, input logic [CHAR_W-1:0] ch, input logic rs,
			input logic [QIDX_W-1:0] qidx);
		int                len;
		logic [QIDX_W-1:0] mask;
		logic [QIDX_W-1:0] slot;
		logic [1:0]        code;
		count_beat_t       owed;
		len  = active_length();
		mask = len_mask(len);
		// a shorter length clamps the bases already held
		if (bases_seen > len)
			bases_seen = len;
		if (act == ACT_QUERY) begin
			// index bits above the k-mer are dropped and the masked index is echoed
			slot        = qidx & mask;
			owed.count  = hist_counts[slot];
			owed.index  = slot;
			pending_counts.push_back(owed);
		end else begin
			if (rs) begin
				window_q   = '0;
				bases_seen = 0;
			end
			if (!decode_char(ch, code)) begin
				// a non-acgt byte restarts the window and counts nothing
				window_q   = '0;
				bases_seen = 0;
			end else begin
				window_q = {window_q[2*K_USED-3:0], code};
				if (bases_seen < len)
					bases_seen++;
				if (bases_seen >= len) begin
					slot = window_q & mask;
					// saturate at the top count
					if (hist_counts[slot] != '1)
						hist_counts[slot] = hist_counts[slot] + 1'b1;
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// drivers: inputs change on the falling edge
	// ---------------------------------------------------------------

	// one item beat; valid stays high on return so back-to-back beats need no gap
	task automatic send_item(input logic act, input logic [CHAR_W-1:0] ch, input logic rs,
			input logic [QIDX_W-1:0] qidx);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.action     <= act;
		item_bus.base_char  <= ch;
		item_bus.read_start <= rs;
		item_bus.kmer_index <= qidx;
		do
			@(posedge clk);
		while (!item_bus.ready);
		tally_beat(act, ch, rs, qidx);
	endtask

	// base beats from a string, random kmer_index since it is ignored on a push
	task automatic push_string(input string bases, input logic starts_read);
		for (int i = 0; i < bases.len(); i++)
			send_item(ACT_PUSH, bases[i], starts_read && (i == 0), QIDX_W'($urandom_range(255)));
	endtask

	// query beat, base_char and read_start carry junk
	task automatic query_count(input logic [QIDX_W-1:0] qidx);
		send_item(ACT_QUERY, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)), qidx);
	endtask

	// stop sending, wait for every owed count and for pushes still in flight
	task automatic settle();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// length writes only while the block is idle
	task automatic write_length(input logic [LEN_W-1:0] len);
		settle();
		@(negedge clk);
		cfg_bus.valid       <= 1'b1;
		cfg_bus.kmer_length <= len;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		kmer_len_q = len;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] pick_base();
		case ($urandom_range(7))
			0: return CH_UA;
			1: return CH_UC;
			2: return CH_UG;
			3: return CH_UT;
			4: return CH_LA;
			5: return CH_LC;
			6: return CH_LG;
			default: return CH_LT;
		endcase
	endfunction

	// well-formed reads with random bases, some junk bytes, stray restarts and queries
	task automatic random_reads(input int n_items);
		int                sent;
		int                read_len;
		logic [CHAR_W-1:0] ch;
		logic              rs;
		logic [QIDX_W-1:0] qidx;
		sent = 0;
		while (sent < n_items) begin
			read_len = $urandom_range(1, 24);
			for (int i = 0; i < read_len && sent < n_items; i++) begin
				if ($urandom_range(99) < 20) begin
					// half the queries hit the k-mer just counted, the rest anywhere
					if ($urandom_range(1))
						qidx = QIDX_W'($urandom_range(255));
					else
						qidx = window_q | (QIDX_W'($urandom_range(255)) & ~len_mask(active_length()));
					query_count(qidx);
					sent++;
				end
				if ($urandom_range(99) < 4)
					ch = CHAR_W'($urandom_range(255));
				else
					ch = pick_base();
				// reads mostly open with a restart, rarely one lands mid-read
				if (i == 0)
					rs = ($urandom_range(9) != 0);
				else
					rs = ($urandom_range(99) < 3);
				send_item(ACT_PUSH, ch, rs, QIDX_W'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// receiver and result check: sampled on the rising edge
	// ---------------------------------------------------------------

	always @(negedge clk)
		result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin : check_counts
		count_beat_t owed;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_counts.size() == 0) begin
				$error("count beat with nothing owed: count_value %0d echoed_index %0d",
					result_bus.count_value, result_bus.echoed_index);
				mismatches++;
			end else begin
				owed = pending_counts.pop_front();
				if (result_bus.count_value !== owed.count) begin
					$error("count_value expected %0d got %0d", owed.count, result_bus.count_value);
					mismatches++;
				end
				if (result_bus.echoed_index !== owed.index) begin
					$error("echoed_index expected %0d got %0d", owed.index, result_bus.echoed_index);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any beat on any channel
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("kmer_histogram_counter_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// store comes up zeroed, lowest and highest entry
	task automatic test_cleared_store();
		query_count('0);
		query_count('1);
	endtask

	// all four bases in both cases; acgt is seen twice in the read
	task automatic test_every_base();
		push_string("ACGTacgt", 1'b1);
		query_count({CODE_A, CODE_C, CODE_G, CODE_T});
	endtask

	// length 0 acts as 1, length above K acts as K, wide query index gets masked
	task automatic test_length_range();
		write_length(3'd0);
		send_item(ACT_PUSH, CH_LT, 1'b1, '1);
		query_count('1);
		write_length(3'd7);
		query_count('1);
	endtask

	// junk byte and read start both empty the window
	task automatic test_restarts();
		write_length(3'd2);
		push_string("GG", 1'b1);
		send_item(ACT_PUSH, 8'h00, 1'b0, '0);
		push_string("G", 1'b0);
		push_string("GG", 1'b1);
		query_count({4'h0, CODE_G, CODE_G});
	endtask

	// length change mid-read keeps the window and clamps the bases held
	task automatic test_length_change();
		write_length(3'd4);
		push_string("AC", 1'b1);
		write_length(3'd1);
		push_string("G", 1'b0);
		write_length(3'd2);
		push_string("T", 1'b0);
		query_count({4'h0, CODE_G, CODE_T});
	endtask

	task automatic test_random_sender_idle();
		tx_idle_pct = 17;
		rx_idle_pct = 81;
		write_length(3'd4);
		random_reads(SEGMENT_ITEMS);
		write_length(3'd2);
		random_reads(SEGMENT_ITEMS);
	endtask

	task automatic test_random_receiver_idle();
		tx_idle_pct = 81;
		rx_idle_pct = 17;
		write_length(3'd1);
		random_reads(SEGMENT_ITEMS);
		write_length(3'd3);
		random_reads(SEGMENT_ITEMS);
	endtask

	task automatic test_random_streaming();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_length(3'd0);
		random_reads(SEGMENT_ITEMS);
		write_length(3'd6);
		random_reads(SEGMENT_ITEMS);
		write_length(3'd4);
		random_reads(SEGMENT_ITEMS);
	endtask

	initial begin
		// item and config inputs known from time zero
		arst_n              = 1'b0;
		item_bus.valid      = 1'b0;
		item_bus.action     = ACT_PUSH;
		item_bus.base_char  = '0;
		item_bus.read_start = 1'b0;
		item_bus.kmer_index = '0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.kmer_length = '0;

		kmer_len_q = KMER_LENGTH_RESET;
		window_q   = '0;
		bases_seen = 0;
		foreach (hist_counts[i])
			hist_counts[i] = '0;

		// directed part runs with the first idle mix
		tx_idle_pct = 17;
		rx_idle_pct = 81;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first beats wait out the clearing pass on item ready
		test_cleared_store();
		test_every_base();
		test_length_range();
		test_restarts();
		test_length_change();
		test_random_sender_idle();
		test_random_receiver_idle();
		test_random_streaming();

		settle();
		if (mismatches == 0)
			$display("kmer_histogram_counter_unit: match");
		else
			$display("kmer_histogram_counter_unit: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
design/kmc_pkg.sv
design/kmc_ifs.sv
design/kmc_window.sv
design/kmc_table.sv
design/kmer_histogram_counter_unit.sv
tb/kmer_histogram_counter_unit_tb.sv
